FILE: hdl/cst_pkg.sv
// Package with field widths, result codes and the sequencer microprogram.
`timescale 1ns / 1ps

package cst_pkg;

    localparam int LEN_W   = 9;
    localparam int ACK_W   = 32;
    localparam int KIND_W  = 2;
    localparam int SEQ_W   = 5;
    localparam int OFF_W   = 8;
    localparam int CLEN_W  = 4;
    localparam int TOTAL_W = 6;
    localparam int UPC_W   = 4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_ACK   = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ANNOUNCE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHUNK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESEND   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd3;

    typedef logic [UPC_W-1:0] t_upc;

    // Microprogram addresses.
    localparam t_upc UPC_IDLE     = 4'd0;
    localparam t_upc UPC_DISPATCH = 4'd1;
    localparam t_upc UPC_COUNT    = 4'd2;
    localparam t_upc UPC_ANNOUNCE = 4'd3;
    localparam t_upc UPC_CHUNK    = 4'd4;
    localparam t_upc UPC_DONE     = 4'd5;
    localparam t_upc UPC_ACK      = 4'd6;
    localparam t_upc UPC_TEST     = 4'd7;
    localparam t_upc UPC_SCAN     = 4'd8;
    localparam t_upc UPC_RESEND   = 4'd9;
    localparam t_upc UPC_LAST     = UPC_RESEND;

    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_LATCH   = 4'd1,
        ACT_COUNT   = 4'd2,
        ACT_SEQ_CLR = 4'd3,
        ACT_CHUNK   = 4'd4,
        ACT_FINISH  = 4'd5,
        ACT_ACK     = 4'd6,
        ACT_TEST    = 4'd7,
        ACT_SCAN    = 4'd8,
        ACT_SWEEP   = 4'd9
    } t_act;

    typedef enum logic [2:0] {
        EM_NONE     = 3'd0,
        EM_ANNOUNCE = 3'd1,
        EM_CHUNK    = 3'd2,
        EM_RESEND   = 3'd3,
        EM_DONE     = 3'd4
    } t_emit;

    typedef enum logic [2:0] {
        C_TRUE     = 3'd0,
        C_GO       = 3'd1,
        C_OP_ACK   = 3'd2,
        C_REM_NZ   = 3'd3,
        C_CNT_ZERO = 3'd4,
        C_SEQ_LAST = 3'd5,
        C_SCAN_END = 3'd6,
        C_FOUND    = 3'd7
    } t_cnd;

    typedef struct packed {
        logic  rdy;
        t_act  act;
        t_emit emit;
        t_cnd  cnd;
        t_upc  tgt_t;
        t_upc  tgt_f;
    } t_uword;

    function automatic t_uword cst_rom(input t_upc addr);
        t_uword w;
        w = '{1'b0, ACT_NONE, EM_NONE, C_TRUE, UPC_IDLE, UPC_IDLE};
        unique case (addr)
            UPC_IDLE:     w = '{1'b1, ACT_LATCH,   EM_NONE,     C_GO,
                                UPC_DISPATCH, UPC_IDLE};
            UPC_DISPATCH: w = '{1'b0, ACT_NONE,    EM_NONE,     C_OP_ACK,
                                UPC_ACK, UPC_COUNT};
            UPC_COUNT:    w = '{1'b0, ACT_COUNT,   EM_NONE,     C_REM_NZ,
                                UPC_COUNT, UPC_ANNOUNCE};
            UPC_ANNOUNCE: w = '{1'b0, ACT_SEQ_CLR, EM_ANNOUNCE, C_CNT_ZERO,
                                UPC_DONE, UPC_CHUNK};
            UPC_CHUNK:    w = '{1'b0, ACT_CHUNK,   EM_CHUNK,    C_SEQ_LAST,
                                UPC_IDLE, UPC_CHUNK};
            UPC_DONE:     w = '{1'b0, ACT_FINISH,  EM_DONE,     C_TRUE,
                                UPC_IDLE, UPC_IDLE};
            UPC_ACK:      w = '{1'b0, ACT_ACK,     EM_NONE,     C_TRUE,
                                UPC_TEST, UPC_TEST};
            UPC_TEST:     w = '{1'b0, ACT_TEST,    EM_NONE,     C_TRUE,
                                UPC_SCAN, UPC_SCAN};
            UPC_SCAN:     w = '{1'b0, ACT_SCAN,    EM_NONE,     C_SCAN_END,
                                UPC_RESEND, UPC_SCAN};
            UPC_RESEND:   w = '{1'b0, ACT_SWEEP,   EM_RESEND,   C_FOUND,
                                UPC_IDLE, UPC_DONE};
            default:      w = '{1'b0, ACT_NONE,    EM_NONE,     C_TRUE,
                                UPC_IDLE, UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/cst_if.sv
// Handshake channel interfaces for the input items and the result beats.
`timescale 1ns / 1ps

interface cst_item_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [cst_pkg::LEN_W-1:0]   msg_len;
    logic                        ack_present;
    logic [cst_pkg::ACK_W-1:0]   ack_value;

    modport source (output valid, op, msg_len, ack_present, ack_value, input ready);
    modport sink   (input valid, op, msg_len, ack_present, ack_value, output ready);
endinterface

interface cst_result_if;
    logic                          valid;
    logic                          ready;
    logic [cst_pkg::KIND_W-1:0]    kind;
    logic [cst_pkg::SEQ_W-1:0]     seq_num;
    logic [cst_pkg::OFF_W-1:0]     byte_offset;
    logic [cst_pkg::CLEN_W-1:0]    chunk_len;
    logic [cst_pkg::TOTAL_W-1:0]   chunk_total;
    logic                          last;

    modport source (output valid, kind, seq_num, byte_offset, chunk_len, chunk_total, last,
                    input ready);
    modport sink   (input valid, kind, seq_num, byte_offset, chunk_len, chunk_total, last,
                    output ready);
endinterface

FILE: hdl/chunked_send_ack_tracker_core.sv
// Top level: sender-side chunk tracker with acknowledge bitmap and selective resend.
`timescale 1ns / 1ps

// Sender side of a chunked transfer, run by a small microprogram. A start item
// computes the chunk count by repeated subtraction (one chunk per cycle), then
// emits an announce beat and one descriptor beat per chunk, or a done beat when
// there are no chunks. An acknowledge attempt visits bitmap positions while the
// sweep hunts for the next unacknowledged chunk (at most chunk_total positions)
// and ends in a done beat when every chunk is acknowledged. The bitmap scan, one
// position per cycle, sets the attempt time. A new item is taken only when the
// sequencer is back at its idle step; a finished beat waits in the output register
// without holding up the sequencer unless a second beat is due.
module chunked_send_ack_tracker_core #(
    parameter int CHUNK_BYTES = 8,
    parameter int MAX_CHUNKS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cst_item_if.sink             i_item,
    cst_result_if.source         o_result
);

    localparam int IW       = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CW       = $clog2(MAX_CHUNKS + 1);
    localparam int CAPACITY = MAX_CHUNKS * CHUNK_BYTES;
    localparam int OFFW     = $clog2(CAPACITY + 1);
    localparam int CBW      = $clog2(CHUNK_BYTES + 1);

    cst_pkg::t_upc   r_upc;
    cst_pkg::t_uword w_uw;

    logic [MAX_CHUNKS-1:0]         r_ack_map;
    logic [CW-1:0]                 r_count;
    logic [IW-1:0]                 r_sweep;
    logic [cst_pkg::LEN_W-1:0]     r_saved;
    logic                          r_busy;
    logic [cst_pkg::LEN_W-1:0]     r_rem;
    logic [IW-1:0]                 r_seq;
    logic [IW-1:0]                 r_scan;
    logic [CW-1:0]                 r_left;
    logic                          r_found;
    logic                          r_resend;
    logic                          r_op;
    logic                          r_ack_present;
    logic [cst_pkg::ACK_W-1:0]     r_ack_value;

    logic                          r_out_valid;
    logic [cst_pkg::KIND_W-1:0]    r_kind;
    logic [cst_pkg::SEQ_W-1:0]     r_seq_num;
    logic [cst_pkg::OFF_W-1:0]     r_byte_offset;
    logic [cst_pkg::CLEN_W-1:0]    r_chunk_len;
    logic [cst_pkg::TOTAL_W-1:0]   r_chunk_total;
    logic                          r_last;

    logic                          w_emit_on;
    logic                          w_hold;
    logic                          w_cond;
    logic [cst_pkg::LEN_W-1:0]     w_sat_len;
    logic                          w_seq_last;
    logic [IW-1:0]                 w_p_next;
    logic                          w_hit;
    logic [IW-1:0]                 w_seq_sel;
    logic [OFFW-1:0]               w_off;
    logic [CBW-1:0]                w_len;
    logic                          w_sel_last;

    assign w_uw = cst_pkg::cst_rom(r_upc);

    assign i_item.ready = w_uw.rdy;

    assign w_sat_len = (32'(i_item.msg_len) > CAPACITY) ? cst_pkg::LEN_W'(CAPACITY)
                                                         : i_item.msg_len;
    assign w_seq_last = (CW'(r_seq) + CW'(1)) == r_count;
    assign w_p_next   = ((CW'(r_scan) + CW'(1)) == r_count) ? '0 : r_scan + IW'(1);
    assign w_hit      = !r_ack_map[w_p_next];

    // A resend step only produces a beat when the swept chunk was still open.
    assign w_emit_on = (w_uw.emit != cst_pkg::EM_NONE) &&
                       !(w_uw.emit == cst_pkg::EM_RESEND && !r_resend);
    assign w_hold    = w_emit_on && r_out_valid && !o_result.ready;

    always_comb begin
        unique case (w_uw.cnd)
            cst_pkg::C_TRUE:     w_cond = 1'b1;
            cst_pkg::C_GO:       w_cond = i_item.valid &&
                                          (i_item.op == cst_pkg::OP_START || r_busy);
            cst_pkg::C_OP_ACK:   w_cond = r_op == cst_pkg::OP_ACK;
            cst_pkg::C_REM_NZ:   w_cond = r_rem != '0;
            cst_pkg::C_CNT_ZERO: w_cond = r_count == '0;
            cst_pkg::C_SEQ_LAST: w_cond = w_seq_last;
            cst_pkg::C_SCAN_END: w_cond = w_hit || r_left == CW'(1);
            cst_pkg::C_FOUND:    w_cond = r_found;
            default:             w_cond = 1'b1;
        endcase
    end

    // Descriptor datapath shared by initial sends and resends.
    assign w_seq_sel  = (w_uw.emit == cst_pkg::EM_CHUNK) ? r_seq : r_sweep;
    assign w_sel_last = (CW'(w_seq_sel) + CW'(1)) == r_count;
    assign w_off      = OFFW'(w_seq_sel) * OFFW'(CHUNK_BYTES);
    assign w_len      = w_sel_last ? CBW'(OFFW'(r_saved) - w_off) : CBW'(CHUNK_BYTES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc     <= cst_pkg::UPC_IDLE;
            r_ack_map <= '0;
            r_count   <= '0;
            r_sweep   <= '0;
            r_saved   <= '0;
            r_busy    <= 1'b0;
        end else if (!w_hold) begin
            r_upc <= w_cond ? w_uw.tgt_t : w_uw.tgt_f;
            unique case (w_uw.act)
                cst_pkg::ACT_NONE: begin
                end
                cst_pkg::ACT_LATCH: begin
                    if (i_item.valid) begin
                        r_op          <= i_item.op;
                        r_ack_present <= i_item.ack_present;
                        r_ack_value   <= i_item.ack_value;
                        if (i_item.op == cst_pkg::OP_START) begin
                            r_saved   <= w_sat_len;
                            r_rem     <= w_sat_len;
                            r_count   <= '0;
                            r_ack_map <= '0;
                            r_sweep   <= '0;
                            r_busy    <= 1'b0;
                        end
                    end
                end
                cst_pkg::ACT_COUNT: begin
                    if (r_rem != '0) begin
                        r_rem   <= (r_rem > cst_pkg::LEN_W'(CHUNK_BYTES))
                                   ? r_rem - cst_pkg::LEN_W'(CHUNK_BYTES) : '0;
                        r_count <= r_count + CW'(1);
                    end
                end
                cst_pkg::ACT_SEQ_CLR: begin
                    r_seq <= '0;
                end
                cst_pkg::ACT_CHUNK: begin
                    r_seq  <= r_seq + IW'(1);
                    r_busy <= 1'b1;
                end
                cst_pkg::ACT_FINISH: begin
                    r_busy  <= 1'b0;
                    r_sweep <= '0;
                end
                cst_pkg::ACT_ACK: begin
                    if (r_ack_present && r_ack_value < cst_pkg::ACK_W'(r_count)) begin
                        r_ack_map[r_ack_value[IW-1:0]] <= 1'b1;
                    end
                end
                cst_pkg::ACT_TEST: begin
                    r_resend <= !r_ack_map[r_sweep];
                    r_scan   <= r_sweep;
                    r_left   <= r_count;
                end
                cst_pkg::ACT_SCAN: begin
                    r_scan  <= w_p_next;
                    r_left  <= r_left - CW'(1);
                    r_found <= w_hit;
                end
                cst_pkg::ACT_SWEEP: begin
                    if (r_found) begin
                        r_sweep <= r_scan;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: one beat waits here while the sequencer moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_on && !w_hold) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_on && !w_hold) begin
            r_chunk_total <= cst_pkg::TOTAL_W'(r_count);
            unique case (w_uw.emit)
                cst_pkg::EM_CHUNK, cst_pkg::EM_RESEND: begin
                    r_kind        <= (w_uw.emit == cst_pkg::EM_CHUNK) ? cst_pkg::KIND_CHUNK
                                                                      : cst_pkg::KIND_RESEND;
                    r_seq_num     <= cst_pkg::SEQ_W'(w_seq_sel);
                    r_byte_offset <= cst_pkg::OFF_W'(w_off);
                    r_chunk_len   <= cst_pkg::CLEN_W'(w_len);
                    r_last        <= (w_uw.emit == cst_pkg::EM_CHUNK) ? w_seq_last : r_found;
                end
                cst_pkg::EM_DONE: begin
                    r_kind        <= cst_pkg::KIND_DONE;
                    r_seq_num     <= '0;
                    r_byte_offset <= '0;
                    r_chunk_len   <= '0;
                    r_last        <= 1'b1;
                end
                default: begin
                    r_kind        <= cst_pkg::KIND_ANNOUNCE;
                    r_seq_num     <= '0;
                    r_byte_offset <= '0;
                    r_chunk_len   <= '0;
                    r_last        <= 1'b0;
                end
            endcase
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.kind        = r_kind;
    assign o_result.seq_num     = r_seq_num;
    assign o_result.byte_offset = r_byte_offset;
    assign o_result.chunk_len   = r_chunk_len;
    assign o_result.chunk_total = r_chunk_total;
    assign o_result.last        = r_last;

`ifndef NO_ASSERTIONS
    a_busy_has_chunks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_count != '0)
        else $error("active message with zero chunks");

    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> CW'(r_sweep) < r_count)
        else $error("sweep position beyond chunk count");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc == cst_pkg::UPC_SCAN |-> r_left != '0)
        else $error("bitmap scan ran past the chunk count");

    a_upc_in_program: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc <= cst_pkg::UPC_LAST)
        else $error("step counter left the microprogram");
`endif

endmodule

FILE: test/chunked_send_ack_tracker_core_tb.sv
// Self-checking testbench for the chunk send and acknowledge tracker core.
`timescale 1ns / 1ps

module chunked_send_ack_tracker_core_tb;

    localparam int CHUNK_BYTES = 8;
    localparam int MAX_CHUNKS  = 32;
    localparam int CAPACITY    = CHUNK_BYTES * MAX_CHUNKS;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [cst_pkg::KIND_W-1:0]  kind;
        logic [cst_pkg::SEQ_W-1:0]   seq_num;
        logic [cst_pkg::OFF_W-1:0]   byte_offset;
        logic [cst_pkg::CLEN_W-1:0]  chunk_len;
        logic [cst_pkg::TOTAL_W-1:0] chunk_total;
        logic                        last;
    } t_beat;

    logic i_clk;
    logic i_rst_n;

    cst_item_if   item_ch ();
    cst_result_if result_ch ();

    chunked_send_ack_tracker_core #(
        .CHUNK_BYTES(CHUNK_BYTES),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch)
    );

    // Shadow copy of the sender state, advanced at every accepted input beat.
    logic [MAX_CHUNKS-1:0] trk_acked;
    int                    trk_count;
    int                    trk_sweep;
    int                    trk_len;
    bit                    trk_busy;

    t_beat due_beats[$];

    bit no_idle;
    int hold_req;
    int cycles;
    int errors;
    int beats_checked;
    int n_starts;
    int n_attempts;
    int n_ignored;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_beat info_beat(input logic [cst_pkg::KIND_W-1:0] k,
                                        input int total);
        t_beat b;
        b             = '0;
        b.kind        = k;
        b.chunk_total = total[cst_pkg::TOTAL_W-1:0];
        return b;
    endfunction

    function automatic t_beat chunk_beat(input logic [cst_pkg::KIND_W-1:0] k, input int s);
        t_beat b;
        int    blen;
        int    off;
        blen = CHUNK_BYTES;
        // The final chunk carries the remainder, or a full chunk if there is none.
        if (s + 1 == trk_count) begin
            blen = trk_len % CHUNK_BYTES;
            if (blen == 0) blen = CHUNK_BYTES;
        end
        off           = s * CHUNK_BYTES;
        b.kind        = k;
        b.seq_num     = s[cst_pkg::SEQ_W-1:0];
        b.byte_offset = off[cst_pkg::OFF_W-1:0];
        b.chunk_len   = blen[cst_pkg::CLEN_W-1:0];
        b.chunk_total = trk_count[cst_pkg::TOTAL_W-1:0];
        b.last        = 1'b0;
        return b;
    endfunction

    function automatic void track_sender(input logic op,
                                         input logic [cst_pkg::LEN_W-1:0] len,
                                         input logic ap,
                                         input logic [cst_pkg::ACK_W-1:0] av);
        t_beat fresh[$];
        t_beat b;
        int    p;
        bit    found;
        found = 1'b0;
        if (op == cst_pkg::OP_START) begin
            trk_len   = (int'(len) > CAPACITY) ? CAPACITY : int'(len);
            trk_count = (trk_len + CHUNK_BYTES - 1) / CHUNK_BYTES;
            trk_acked = '0;
            trk_sweep = 0;
            fresh.push_back(info_beat(cst_pkg::KIND_ANNOUNCE, trk_count));
            if (trk_count == 0) begin
                trk_busy = 1'b0;
                fresh.push_back(info_beat(cst_pkg::KIND_DONE, 0));
            end else begin
                trk_busy = 1'b1;
                for (int s = 0; s < trk_count; s++) begin
                    fresh.push_back(chunk_beat(cst_pkg::KIND_CHUNK, s));
                end
            end
        end else if (trk_busy) begin
            if (ap && av < 32'(trk_count)) trk_acked[av[cst_pkg::SEQ_W-1:0]] = 1'b1;
            if (!trk_acked[trk_sweep]) begin
                fresh.push_back(chunk_beat(cst_pkg::KIND_RESEND, trk_sweep));
            end
            for (int i = 1; i <= trk_count; i++) begin
                p = (trk_sweep + i) % trk_count;
                if (!trk_acked[p]) begin
                    trk_sweep = p;
                    found     = 1'b1;
                    break;
                end
            end
            if (!found) begin
                trk_busy  = 1'b0;
                trk_sweep = 0;
                fresh.push_back(info_beat(cst_pkg::KIND_DONE, trk_count));
            end
        end
        if (fresh.size() > 0) begin
            b = fresh[fresh.size() - 1];
            b.last = 1'b1;
            fresh[fresh.size() - 1] = b;
        end
        foreach (fresh[j]) due_beats.push_back(fresh[j]);
    endfunction

    task automatic send_item(input logic op, input logic [cst_pkg::LEN_W-1:0] len,
                             input logic ap, input logic [cst_pkg::ACK_W-1:0] av);
        int gap;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid       <= 1'b1;
        item_ch.op          <= op;
        item_ch.msg_len     <= len;
        item_ch.ack_present <= ap;
        item_ch.ack_value   <= av;
        do @(posedge i_clk); while (!item_ch.ready);
        if (op == cst_pkg::OP_START) n_starts++;
        else if (trk_busy) n_attempts++;
        else n_ignored++;
        track_sender(op, len, ap, av);
    endtask

    // Withdraws the offer and waits until every predicted beat has arrived.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge i_clk); while (due_beats.size() != 0);
    endtask

    function automatic logic [cst_pkg::LEN_W-1:0] rand_msg_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return cst_pkg::LEN_W'(CAPACITY);
        if (r == 2) return cst_pkg::LEN_W'($urandom_range(129, 255));
        return cst_pkg::LEN_W'($urandom_range(1, 40));
    endfunction

    // Mostly acknowledges a chunk still outstanding, so that messages complete.
    task automatic pick_ack(output logic ap, output logic [cst_pkg::ACK_W-1:0] av);
        int r;
        int s;
        r  = $urandom_range(0, 99);
        ap = 1'b1;
        if (r < 60) begin
            s = $urandom_range(0, trk_count - 1);
            for (int i = 0; i < trk_count; i++) begin
                if (!trk_acked[(s + i) % trk_count]) begin
                    s = (s + i) % trk_count;
                    break;
                end
            end
            av = cst_pkg::ACK_W'(s);
        end else if (r < 72) begin
            ap = 1'b0;
            av = $urandom;
        end else if (r < 82) begin
            av = cst_pkg::ACK_W'($urandom_range(0, trk_count - 1));
        end else if (r < 92) begin
            av = cst_pkg::ACK_W'(trk_count + $urandom_range(0, 40));
        end else begin
            ap = 1'($urandom_range(0, 1));
            av = $urandom;
        end
    endtask

    task automatic test_idle_attempt();
        send_item(cst_pkg::OP_ACK, cst_pkg::LEN_W'(CAPACITY), 1'b1, '0);
        send_item(cst_pkg::OP_ACK, '0, 1'b0, '1);
    endtask

    task automatic test_short_messages();
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(0), 1'b0, '0);
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(1), 1'b1, '1);
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(8), 1'b0, '0);
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(9), 1'b0, '0);
    endtask

    // Three chunks: timeout, out of range, repeated and fresh acknowledges.
    task automatic test_ack_handling();
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(20), 1'b0, '0);
        send_item(cst_pkg::OP_ACK, '0, 1'b0, '0);
        send_item(cst_pkg::OP_ACK, '0, 1'b1, cst_pkg::ACK_W'(3));
        send_item(cst_pkg::OP_ACK, '0, 1'b1, '1);
        send_item(cst_pkg::OP_ACK, '0, 1'b1, cst_pkg::ACK_W'(1));
        send_item(cst_pkg::OP_ACK, '0, 1'b1, cst_pkg::ACK_W'(1));
        send_item(cst_pkg::OP_ACK, '0, 1'b1, cst_pkg::ACK_W'(0));
        send_item(cst_pkg::OP_ACK, '0, 1'b1, cst_pkg::ACK_W'(2));
        send_item(cst_pkg::OP_ACK, '1, 1'b1, cst_pkg::ACK_W'(0));
    endtask

    task automatic test_restart();
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(CAPACITY), 1'b0, '0);
        send_item(cst_pkg::OP_ACK, '0, 1'b1, cst_pkg::ACK_W'(MAX_CHUNKS - 1));
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(CAPACITY - 1), 1'b0, '0);
    endtask

    task automatic test_random_transfers(input int n_items);
        int                        done_items;
        logic                      ap;
        logic [cst_pkg::ACK_W-1:0] av;
        done_items = 0;
        while (done_items < n_items) begin
            if (!trk_busy) begin
                if ($urandom_range(0, 19) == 0) begin
                    send_item(cst_pkg::OP_ACK, cst_pkg::LEN_W'($urandom_range(0, 256)),
                              1'($urandom_range(0, 1)), $urandom);
                end else begin
                    send_item(cst_pkg::OP_START, rand_msg_len(), 1'($urandom_range(0, 1)),
                              $urandom);
                    done_items++;
                end
            end else if ($urandom_range(0, 39) == 0) begin
                send_item(cst_pkg::OP_START, rand_msg_len(), 1'($urandom_range(0, 1)),
                          $urandom);
                done_items++;
            end else begin
                pick_ack(ap, av);
                send_item(cst_pkg::OP_ACK, cst_pkg::LEN_W'($urandom_range(0, 256)), ap, av);
                done_items++;
            end
        end
    endtask

    // The result side stalls for a long stretch while full messages keep coming.
    task automatic test_backpressure();
        wait_drained();
        hold_req = HOLD_CYCLES;
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(CAPACITY), 1'b0, '0);
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(CAPACITY), 1'b0, '0);
        send_item(cst_pkg::OP_ACK, '0, 1'b1, cst_pkg::ACK_W'(5));
        send_item(cst_pkg::OP_START, cst_pkg::LEN_W'(100), 1'b0, '0);
        wait_drained();
    endtask

    task automatic report_beat(input string what, input t_beat want, input t_beat got);
        errors++;
        if (errors <= 10) begin
            $display("%s: expected kind %0d seq %0d off %0d len %0d total %0d last %0b,",
                     what, want.kind, want.seq_num, want.byte_offset, want.chunk_len,
                     want.chunk_total, want.last);
            $display("    got kind %0d seq %0d off %0d len %0d total %0d last %0b",
                     got.kind, got.seq_num, got.byte_offset, got.chunk_len,
                     got.chunk_total, got.last);
        end
    endtask

    always @(posedge i_clk) begin : check_beats
        t_beat got;
        t_beat want;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got.kind        = result_ch.kind;
            got.seq_num     = result_ch.seq_num;
            got.byte_offset = result_ch.byte_offset;
            got.chunk_len   = result_ch.chunk_len;
            got.chunk_total = result_ch.chunk_total;
            got.last        = result_ch.last;
            beats_checked++;
            if (due_beats.size() == 0) begin
                report_beat("Unexpected result beat", '0, got);
            end else begin
                want = due_beats.pop_front();
                if (got !== want) report_beat("Result mismatch", want, got);
            end
        end
    end

    // Result-side ready: random stall bursts, plus one long hold on request.
    initial begin : drive_ready
        int burst;
        int hold_left;
        burst     = 0;
        hold_left = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (burst > 0) begin
                burst--;
                result_ch.ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 7) - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run exceeded %0d cycles with %0d results outstanding.",
                     CYCLE_LIMIT, due_beats.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        no_idle       = 1'b0;
        hold_req      = 0;
        cycles        = 0;
        errors        = 0;
        beats_checked = 0;
        n_starts      = 0;
        n_attempts    = 0;
        n_ignored     = 0;
        trk_acked     = '0;
        trk_count     = 0;
        trk_sweep     = 0;
        trk_len       = 0;
        trk_busy      = 1'b0;

        i_rst_n             <= 1'b0;
        item_ch.valid       <= 1'b0;
        item_ch.op          <= cst_pkg::OP_START;
        item_ch.msg_len     <= '0;
        item_ch.ack_present <= 1'b0;
        item_ch.ack_value   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_attempt();
        test_short_messages();
        test_ack_handling();
        test_restart();
        test_random_transfers(160);
        test_backpressure();
        no_idle = 1'b1;
        test_random_transfers(40);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d message starts and %0d acknowledge attempts, %0d more while idle.",
                 n_starts, n_attempts, n_ignored);
        $display("Checked %0d result beats with %0d mismatches, including one long output stall.",
                 beats_checked, errors);
        if (errors == 0 && due_beats.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
